// ===== design/cl1sgd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and codes for the cumulative L1 SGD weight update block.
// No dependencies; every other design file imports this package.
package cl1sgd_pkg;

	// Default sizes of the two weight stores
	localparam int NUM_FEATURE_WEIGHTS_DEF = 65536;
	localparam int MAX_LABELS_DEF          = 64;

	// Field widths
	localparam int IDX_IN_W = 16;
	localparam int TARGET_W = 10;
	localparam int PROB_W   = 17;
	localparam int VAL_W    = 32;
	localparam int LR_W     = 16;
	localparam int CP_W     = 31;

	// Fixed-point datapath widths
	localparam int FRAC_W     = 16;
	localparam int ROUND_HALF = 32768;
	localparam int G_W        = TARGET_W + FRAC_W + 1;   // gradient, signed
	localparam int P1_W       = LR_W + 1 + G_W;          // lr * gradient
	localparam int S_W        = P1_W - FRAC_W;           // scaled gradient
	localparam int P2_W       = S_W + VAL_W;             // scaled gradient * feature
	localparam int STEP_W     = P2_W - FRAC_W;           // weight step

	// Queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

	// Configuration port
	localparam int APB_AW      = 3;
	localparam int APB_DW      = 32;
	localparam int REG_SEL_BIT = 2;

	// Action codes
	localparam logic ACT_FEATURE    = 1'b0;
	localparam logic ACT_TRANSITION = 1'b1;

	// Register indexes
	localparam logic REG_LEARNING_RATE = 1'b0;
	localparam logic REG_CUM_PENALTY   = 1'b1;

	typedef struct packed {
		logic                       action;
		logic [IDX_IN_W-1:0]        param_index;
		logic [TARGET_W-1:0]        target;
		logic [PROB_W-1:0]          prob;
		logic signed [VAL_W-1:0]    feature_value;
	} in_item_t;

	typedef struct packed {
		logic signed [VAL_W-1:0]    new_weight;
		logic signed [VAL_W-1:0]    applied_penalty;
		logic                       saturated;
	} out_item_t;

	// Classified update waiting for the read-modify-write
	typedef struct packed {
		logic                       action;
		logic [IDX_IN_W-1:0]        param_index;
		logic                       oob;
		logic signed [STEP_W-1:0]   step;
	} upd_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_SUM,
		BK_CLIP,
		BK_WRITE
	} back_state_t;

endpackage

// ===== design/cl1sgd_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts input beats, range-checks the index and computes the
// weight step through two registered multiplies. Depends on cl1sgd_pkg.
module cl1sgd_front #(
	parameter int NUM_FEATURE_WEIGHTS = cl1sgd_pkg::NUM_FEATURE_WEIGHTS_DEF,
	parameter int MAX_LABELS          = cl1sgd_pkg::MAX_LABELS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  cl1sgd_pkg::in_item_t            item,
	input  logic [cl1sgd_pkg::LR_W-1:0]     learning_rate,
	input  logic [cl1sgd_pkg::QCNT_W-1:0]   q_count,
	input  logic                            clearing,
	output logic                            push,
	output cl1sgd_pkg::upd_t                push_entry
);
	import cl1sgd_pkg::*;

	localparam int TR_DEPTH = MAX_LABELS * MAX_LABELS;

	logic                     accept;
	logic                     oob_in;
	logic [QCNT_W:0]          in_flight;
	logic signed [G_W-1:0]    grad;
	logic signed [P1_W-1:0]   prod1;
	logic signed [P1_W-1:0]   rnd1;
	logic signed [S_W-1:0]    s_val;
	logic signed [P2_W-1:0]   prod2;
	logic signed [P2_W-1:0]   rnd2;

	logic                     v_s1;
	logic                     act_s1;
	logic [IDX_IN_W-1:0]      idx_s1;
	logic                     oob_s1;
	logic signed [VAL_W-1:0]  fv_s1;
	logic signed [P1_W-1:0]   prod_s1;

	logic                     v_s2;
	logic                     act_s2;
	logic [IDX_IN_W-1:0]      idx_s2;
	logic                     oob_s2;
	logic signed [S_W-1:0]    s_s2;
	logic signed [P2_W-1:0]   prod_s2;

	// Hold input while clearing or while the queue could not take every beat in flight
	assign in_flight  = {1'b0, q_count} + (QCNT_W+1)'(v_s1) + (QCNT_W+1)'(v_s2);
	assign item_stall = clearing || (in_flight >= (QCNT_W+1)'(Q_DEPTH));
	assign accept     = item_valid && !item_stall;

	// Classify the index against the selected store depth
	always_comb begin
		if (item.action == ACT_TRANSITION) begin
			oob_in = 32'(item.param_index) >= 32'(TR_DEPTH);
		end else begin
			oob_in = 32'(item.param_index) >= 32'(NUM_FEATURE_WEIGHTS);
		end
	end

	// Gradient and first product
	assign grad  = $signed({1'b0, item.target, {FRAC_W{1'b0}}}) - $signed(G_W'(item.prob));
	assign prod1 = $signed({1'b0, learning_rate}) * grad;

	// Round the scaled gradient half up, then second product
	assign rnd1  = prod_s1 + $signed(P1_W'(ROUND_HALF));
	assign s_val = rnd1[FRAC_W +: S_W];
	assign prod2 = s_val * fv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1  <= item.action;
			idx_s1  <= item.param_index;
			oob_s1  <= oob_in;
			fv_s1   <= item.feature_value;
			prod_s1 <= prod1;
		end
	end

	// Stage 2 payload
	always_ff @(posedge clk) begin
		if (v_s1) begin
			act_s2  <= act_s1;
			idx_s2  <= idx_s1;
			oob_s2  <= oob_s1;
			s_s2    <= s_val;
			prod_s2 <= prod2;
		end
	end

	// Final rounding of feature steps (transition steps take the scaled gradient) and push into the queue
	assign rnd2 = prod_s2 + $signed(P2_W'(ROUND_HALF));
	always_comb begin
		push                   = v_s2;
		push_entry.action      = act_s2;
		push_entry.param_index = idx_s2;
		push_entry.oob         = oob_s2;
		if (act_s2 == ACT_TRANSITION) begin
			push_entry.step = {{(STEP_W-S_W){s_s2[S_W-1]}}, s_s2};
		end else begin
			push_entry.step = rnd2[FRAC_W +: STEP_W];
		end
	end

endmodule

// ===== design/cl1sgd_queue.sv =====
`timescale 1ns / 1ps
// Short FIFO of classified updates between front and back end.
// Depends on cl1sgd_pkg for the entry type and depth.
module cl1sgd_queue (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  cl1sgd_pkg::upd_t                push_entry,
	input  logic                            pop,
	output logic                            head_valid,
	output cl1sgd_pkg::upd_t                head,
	output logic [cl1sgd_pkg::QCNT_W-1:0]   count
);
	import cl1sgd_pkg::*;

	upd_t              entry_q [Q_DEPTH];
	logic [Q_AW-1:0]   wr_ptr_q;
	logic [Q_AW-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head_valid = count_q != '0;
	assign head       = entry_q[rd_ptr_q];
	assign count      = count_q;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

// ===== design/cl1sgd_back.sv =====
`timescale 1ns / 1ps
// Back end: owns both weight/penalty stores, clears them after reset and runs
// the read-modify-write with saturation and L1 clipping. Depends on cl1sgd_pkg.
module cl1sgd_back #(
	parameter int NUM_FEATURE_WEIGHTS = cl1sgd_pkg::NUM_FEATURE_WEIGHTS_DEF,
	parameter int MAX_LABELS          = cl1sgd_pkg::MAX_LABELS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            head_valid,
	input  cl1sgd_pkg::upd_t                head,
	output logic                            pop,
	input  logic [cl1sgd_pkg::CP_W-1:0]     cumulative_penalty,
	output logic                            clearing,
	output logic                            result_valid,
	input  logic                            result_stall,
	output cl1sgd_pkg::out_item_t           result
);
	import cl1sgd_pkg::*;

	localparam int FW_DEPTH  = NUM_FEATURE_WEIGHTS;
	localparam int TR_DEPTH  = MAX_LABELS * MAX_LABELS;
	localparam int FW_AW     = $clog2(FW_DEPTH);
	localparam int TR_AW     = $clog2(TR_DEPTH);
	localparam int CLR_DEPTH = (FW_DEPTH > TR_DEPTH) ? FW_DEPTH : TR_DEPTH;
	localparam int CLR_AW    = $clog2(CLR_DEPTH);
	localparam int IDX_W     = (FW_AW > IDX_IN_W) ? FW_AW : IDX_IN_W;
	localparam int SUM_W     = STEP_W + 1;
	localparam int CL_W      = VAL_W + 2;
	localparam int NP_W      = VAL_W + 4;
	localparam int MEM_W     = 2 * VAL_W;

	localparam logic signed [SUM_W-1:0] SUM_MAX = {{(SUM_W-31){1'b0}}, {31{1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {{(SUM_W-31){1'b1}}, {31{1'b0}}};
	localparam logic signed [NP_W-1:0]  NP_MAX  = {{(NP_W-31){1'b0}}, {31{1'b1}}};
	localparam logic signed [NP_W-1:0]  NP_MIN  = {{(NP_W-31){1'b1}}, {31{1'b0}}};

	back_state_t state_q, state_d;

	// Stores: weight in the upper half, applied penalty in the lower half
	logic [MEM_W-1:0] fmem [FW_DEPTH];
	logic [MEM_W-1:0] tmem [TR_DEPTH];
	logic [MEM_W-1:0] f_rdata_q;
	logic [MEM_W-1:0] t_rdata_q;

	logic              rd_en;
	logic              f_we;
	logic              t_we;
	logic [FW_AW-1:0]  f_raddr;
	logic [TR_AW-1:0]  t_raddr;
	logic [FW_AW-1:0]  f_waddr;
	logic [TR_AW-1:0]  t_waddr;
	logic [MEM_W-1:0]  wdata;
	logic              fire;
	logic              clr_done;

	logic [CLR_AW-1:0] clr_q;
	upd_t              cur_q;
	logic [IDX_W-1:0]  head_idx_w;
	logic [IDX_W-1:0]  cur_idx_w;

	logic [MEM_W-1:0]         rdata;
	logic signed [VAL_W-1:0]  wt_rd;
	logic signed [SUM_W-1:0]  sum;
	logic signed [VAL_W-1:0]  z_sat;
	logic                     hit;
	logic signed [VAL_W-1:0]  z_q;
	logic signed [VAL_W-1:0]  pen_q;
	logic                     hit_q;

	logic signed [CL_W-1:0]   z_cl;
	logic signed [CL_W-1:0]   u_cl;
	logic signed [CL_W-1:0]   p_cl;
	logic signed [CL_W-1:0]   t_cl;
	logic signed [CL_W-1:0]   w_cl;
	logic signed [CL_W-1:0]   w_q;

	logic signed [NP_W-1:0]   np_sum;
	logic signed [VAL_W-1:0]  np_sat;

	logic                     result_valid_q;
	out_item_t                result_q;

	assign clearing     = state_q == BK_CLEAR;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Index to store addresses
	assign head_idx_w = IDX_W'(head.param_index);
	assign cur_idx_w  = IDX_W'(cur_q.param_index);
	assign f_raddr    = head_idx_w[FW_AW-1:0];
	assign t_raddr    = head.param_index[TR_AW-1:0];
	assign clr_done   = clr_q == CLR_AW'(CLR_DEPTH - 1);

	// Gradient step with saturation
	assign rdata = (cur_q.action == ACT_TRANSITION) ? t_rdata_q : f_rdata_q;
	assign wt_rd = rdata[MEM_W-1:VAL_W];
	assign sum   = {{(SUM_W-VAL_W){wt_rd[VAL_W-1]}}, wt_rd}
		+ {{(SUM_W-STEP_W){cur_q.step[STEP_W-1]}}, cur_q.step};
	always_comb begin
		hit = 1'b0;
		if (sum > SUM_MAX) begin
			z_sat = SUM_MAX[VAL_W-1:0];
			hit   = 1'b1;
		end else if (sum < SUM_MIN) begin
			z_sat = SUM_MIN[VAL_W-1:0];
			hit   = 1'b1;
		end else begin
			z_sat = sum[VAL_W-1:0];
		end
	end

	// Clip toward zero without crossing it
	assign z_cl = {{(CL_W-VAL_W){z_q[VAL_W-1]}}, z_q};
	assign u_cl = {{(CL_W-CP_W){1'b0}}, cumulative_penalty};
	assign p_cl = {{(CL_W-VAL_W){pen_q[VAL_W-1]}}, pen_q};
	always_comb begin
		if (z_q > 0) begin
			t_cl = z_cl - u_cl - p_cl;
			w_cl = (t_cl < 0) ? '0 : t_cl;
		end else begin
			t_cl = z_cl + u_cl - p_cl;
			w_cl = (t_cl > 0) ? '0 : t_cl;
		end
	end

	// Accumulate the applied penalty, saturating
	assign np_sum = {{(NP_W-VAL_W){pen_q[VAL_W-1]}}, pen_q}
		+ {{(NP_W-CL_W){w_q[CL_W-1]}}, w_q}
		- {{(NP_W-VAL_W){z_q[VAL_W-1]}}, z_q};
	always_comb begin
		if (np_sum > NP_MAX) begin
			np_sat = NP_MAX[VAL_W-1:0];
		end else if (np_sum < NP_MIN) begin
			np_sat = NP_MIN[VAL_W-1:0];
		end else begin
			np_sat = np_sum[VAL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequence: clear, pop and read, sum, clip, write back and emit
	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		rd_en   = 1'b0;
		f_we    = 1'b0;
		t_we    = 1'b0;
		f_waddr = cur_idx_w[FW_AW-1:0];
		t_waddr = cur_q.param_index[TR_AW-1:0];
		wdata   = {w_q[VAL_W-1:0], np_sat};
		fire    = 1'b0;
		unique case (state_q)
			BK_CLEAR: begin
				f_waddr = clr_q[FW_AW-1:0];
				t_waddr = clr_q[TR_AW-1:0];
				wdata   = '0;
				f_we    = 32'(clr_q) < 32'(FW_DEPTH);
				t_we    = 32'(clr_q) < 32'(TR_DEPTH);
				if (clr_done) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (head_valid) begin
					pop     = 1'b1;
					rd_en   = 1'b1;
					state_d = BK_SUM;
				end
			end
			BK_SUM: begin
				state_d = BK_CLIP;
			end
			BK_CLIP: begin
				state_d = BK_WRITE;
			end
			BK_WRITE: begin
				fire = !result_valid_q || !result_stall;
				if (fire) begin
					f_we    = !cur_q.oob && (cur_q.action == ACT_FEATURE);
					t_we    = !cur_q.oob && (cur_q.action == ACT_TRANSITION);
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// Clear sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clearing && !clr_done) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// Store ports
	always_ff @(posedge clk) begin
		if (f_we) begin
			fmem[f_waddr] <= wdata;
		end
		if (rd_en) begin
			f_rdata_q <= fmem[f_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (t_we) begin
			tmem[t_waddr] <= wdata;
		end
		if (rd_en) begin
			t_rdata_q <= tmem[t_raddr];
		end
	end

	// Working registers of the item in progress
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (state_q == BK_SUM) begin
			z_q   <= z_sat;
			hit_q <= hit;
			pen_q <= rdata[VAL_W-1:0];
		end
		if (state_q == BK_CLIP) begin
			w_q <= w_cl;
		end
	end

	// Output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fire) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			if (cur_q.oob) begin
				result_q <= '0;
			end else begin
				result_q.new_weight      <= w_q[VAL_W-1:0];
				result_q.applied_penalty <= np_sat;
				result_q.saturated       <= hit_q;
			end
		end
	end

endmodule

// ===== design/cumulative_l1_sgd_weight_update.sv =====
`timescale 1ns / 1ps
// Cumulative L1 SGD weight update, top level.
// Input channel: item_valid / item_stall carry one update request per beat
// (action, param_index, target, prob, feature_value).
// Result channel: result_valid / result_stall carry one result beat per input
// beat, in input order (new_weight, applied_penalty, saturated).
// Configuration: APB-style port, learning_rate at 0x0, cumulative_penalty at
// 0x4; pready is always high. Write only while no item is in flight.
// Items are processed one at a time: the back end pops an item only after
// the read-modify-write sequence of the last one has written it back.
// Reset: both stores are cleared by a sweep over max(NUM_FEATURE_WEIGHTS,
// MAX_LABELS*MAX_LABELS) addresses (65536 by default), during which item_stall
// is high; configuration writes are taken as usual.
// Receiver stall: the finished result holds in the output register; the front
// end keeps accepting until its beats in flight would fill the 4-entry queue,
// then raises item_stall.
// Depends on cl1sgd_pkg, cl1sgd_front, cl1sgd_queue and cl1sgd_back.
module cumulative_l1_sgd_weight_update #(
	parameter int NUM_FEATURE_WEIGHTS = cl1sgd_pkg::NUM_FEATURE_WEIGHTS_DEF,
	parameter int MAX_LABELS          = cl1sgd_pkg::MAX_LABELS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  cl1sgd_pkg::in_item_t            item,
	output logic                            result_valid,
	input  logic                            result_stall,
	output cl1sgd_pkg::out_item_t           result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [cl1sgd_pkg::APB_AW-1:0]   paddr,
	input  logic [cl1sgd_pkg::APB_DW-1:0]   pwdata,
	output logic [cl1sgd_pkg::APB_DW-1:0]   prdata,
	output logic                            pready
);
	import cl1sgd_pkg::*;

	logic [LR_W-1:0]   lr_q;
	logic [CP_W-1:0]   cp_q;
	logic              cfg_wr;
	logic              clearing;
	logic              push;
	upd_t              push_entry;
	logic              pop;
	logic              head_valid;
	upd_t              head;
	logic [QCNT_W-1:0] q_count;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q <= '0;
			cp_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[REG_SEL_BIT])
				REG_LEARNING_RATE: lr_q <= pwdata[LR_W-1:0];
				REG_CUM_PENALTY:   cp_q <= pwdata[CP_W-1:0];
				default:           lr_q <= lr_q;
			endcase
		end
	end

	// Register readback
	always_comb begin
		unique case (paddr[REG_SEL_BIT])
			REG_LEARNING_RATE: prdata = APB_DW'(lr_q);
			REG_CUM_PENALTY:   prdata = APB_DW'(cp_q);
			default:           prdata = '0;
		endcase
	end

	cl1sgd_front #(
		.NUM_FEATURE_WEIGHTS (NUM_FEATURE_WEIGHTS),
		.MAX_LABELS          (MAX_LABELS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.item          (item),
		.learning_rate (lr_q),
		.q_count       (q_count),
		.clearing      (clearing),
		.push          (push),
		.push_entry    (push_entry)
	);

	cl1sgd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head),
		.count      (q_count)
	);

	cl1sgd_back #(
		.NUM_FEATURE_WEIGHTS (NUM_FEATURE_WEIGHTS),
		.MAX_LABELS          (MAX_LABELS)
	) u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.head_valid         (head_valid),
		.head               (head),
		.pop                (pop),
		.cumulative_penalty (cp_q),
		.clearing           (clearing),
		.result_valid       (result_valid),
		.result_stall       (result_stall),
		.result             (result)
	);

endmodule
